FILE: hw/rtl/bitmap_font_text_renderer_unit_macros.svh
// assertion macros for the bitmap font text renderer
// used by the controller; no other dependencies
`ifndef BITMAP_FONT_TEXT_RENDERER_UNIT_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/bfr_pkg.sv
// types and constants of the bitmap font text renderer
// no dependencies
`default_nettype none

package bfr_pkg;

    localparam int FONT_BYTES = 8192;
    localparam int FONT_AW    = 13;
    localparam int GLYPH_COLS = 8;
    localparam int CFG_AW     = 5;
    localparam int CFG_IW     = 3;

    // request types
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_CURSOR = 2'd1;
    localparam logic [1:0] REQ_CHAR   = 2'd2;

    // special character codes
    localparam logic [7:0] CHAR_NUL = 8'd0;
    localparam logic [7:0] CHAR_NL  = 8'd10;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_FRAME_BASE   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_LINE_STRIDE  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH = 3'd2;
    localparam logic [CFG_IW-1:0] REG_GLYPH_STRIDE = 3'd3;
    localparam logic [CFG_IW-1:0] REG_DRAW_COLOR   = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [12:0] font_addr;
        logic [7:0]  font_data;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [7:0]  char_code;
    } t_req;

    typedef struct packed {
        logic [31:0] pixel_word_addr;
        logic [7:0]  pixel_mask;
        logic [31:0] pixel_color;
        logic        last_row;
    } t_res;

    typedef struct packed {
        logic [31:0] frame_base_word;
        logic [15:0] line_stride;
        logic [15:0] screen_width;
        logic [5:0]  glyph_stride;
        logic [31:0] draw_color;
    } t_cfg;

    typedef struct packed {
        logic load_we;
        logic set_cursor;
        logic newline;
        logic char_start;
        logic base;
        logic row_issue;
        logic row_last;
    } t_dp_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_ROWS
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/bfr_regs.sv
// configuration register file behind the apb-style port
// depends on bfr_pkg
`default_nettype none

module bfr_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bfr_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output bfr_pkg::t_cfg                   o_cfg
);

    bfr_pkg::t_cfg                 r_cfg;
    logic                          wr_en;
    logic [bfr_pkg::CFG_IW-1:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[bfr_pkg::CFG_AW-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base_word <= 32'd0;
            r_cfg.line_stride     <= 16'd1024;
            r_cfg.screen_width    <= 16'd1024;
            r_cfg.glyph_stride    <= 6'd16;
            r_cfg.draw_color      <= 32'hFFFF_FFFF;
        end else if (wr_en) begin
            unique case (idx)
                bfr_pkg::REG_FRAME_BASE:   r_cfg.frame_base_word <= pwdata;
                bfr_pkg::REG_LINE_STRIDE:  r_cfg.line_stride     <= pwdata[15:0];
                bfr_pkg::REG_SCREEN_WIDTH: r_cfg.screen_width    <= pwdata[15:0];
                bfr_pkg::REG_GLYPH_STRIDE: r_cfg.glyph_stride    <= pwdata[5:0];
                bfr_pkg::REG_DRAW_COLOR:   r_cfg.draw_color      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bfr_pkg::REG_FRAME_BASE:   prdata = r_cfg.frame_base_word;
            bfr_pkg::REG_LINE_STRIDE:  prdata = {16'd0, r_cfg.line_stride};
            bfr_pkg::REG_SCREEN_WIDTH: prdata = {16'd0, r_cfg.screen_width};
            bfr_pkg::REG_GLYPH_STRIDE: prdata = {26'd0, r_cfg.glyph_stride};
            bfr_pkg::REG_DRAW_COLOR:   prdata = r_cfg.draw_color;
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bfr_dp.sv
// datapath: glyph store, cursor, row address walk and result register
// depends on bfr_pkg
`default_nettype none

module bfr_dp #(
    parameter int GLYPH_ROWS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bfr_pkg::t_dp_cmd i_cmd,
    input  wire bfr_pkg::t_req   i_req,
    input  wire bfr_pkg::t_cfg   i_cfg,
    output bfr_pkg::t_res        o_res,
    output logic                 o_strobe
);

    logic [7:0]                  r_font [bfr_pkg::FONT_BYTES];
    logic [15:0]                 r_col;
    logic [15:0]                 r_row;
    logic [31:0]                 r_prod;
    logic [31:0]                 r_addr;
    logic [bfr_pkg::FONT_AW-1:0] r_faddr;
    logic [13:0]                 glyph_base;
    logic [16:0]                 col_next;
    logic                        col_wrap;
    logic                        r_strobe;
    bfr_pkg::t_res               r_res;

    assign glyph_base = 14'(i_req.char_code * i_cfg.glyph_stride);
    assign col_next   = {1'b0, r_col} + 17'(bfr_pkg::GLYPH_COLS);
    assign col_wrap   = col_next >= {1'b0, i_cfg.screen_width};
    assign o_res      = r_res;
    assign o_strobe   = r_strobe;

    // glyph store, written by loads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_font[i_req.font_addr] <= i_req.font_data;
        end
    end

    // cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 16'd0;
            r_row <= 16'd0;
        end else if (i_cmd.set_cursor) begin
            r_col <= i_req.start_x;
            r_row <= i_req.start_y;
        end else if (i_cmd.newline || (i_cmd.row_last && col_wrap)) begin
            r_col <= 16'd0;
            r_row <= r_row + 16'(GLYPH_ROWS);
        end else if (i_cmd.row_last) begin
            r_col <= col_next[15:0];
        end
    end

    // address walk: one multiply at accept, one add per stage after
    always_ff @(posedge i_clk) begin
        if (i_cmd.char_start) begin
            r_prod  <= r_row * i_cfg.line_stride;
            r_faddr <= glyph_base[bfr_pkg::FONT_AW-1:0];
        end else if (i_cmd.base) begin
            r_addr <= i_cfg.frame_base_word + {16'd0, r_col} + r_prod;
        end else if (i_cmd.row_issue) begin
            r_addr  <= r_addr + {16'd0, i_cfg.line_stride};
            r_faddr <= r_faddr + 1'b1;
        end
    end

    // one glyph row read per cycle into the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_issue) begin
            r_res.pixel_word_addr <= r_addr;
            r_res.pixel_mask      <= r_font[r_faddr];
            r_res.pixel_color     <= i_cfg.draw_color;
            r_res.last_row        <= i_cmd.row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.row_issue;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bfr_ctrl.sv
// controller: request decode, row sequencing and busy
// depends on bfr_pkg and the assertion macro header
`default_nettype none
`include "bitmap_font_text_renderer_unit_macros.svh"

module bfr_ctrl #(
    parameter int GLYPH_ROWS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [7:0]    i_char_code,
    output logic               o_busy,
    output bfr_pkg::t_dp_cmd   o_cmd
);

    localparam int CW = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam logic [CW-1:0] LAST = CW'(GLYPH_ROWS - 1);

    bfr_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfr_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            bfr_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    unique case (i_req_type)
                        bfr_pkg::REQ_LOAD:   o_cmd.load_we    = 1'b1;
                        bfr_pkg::REQ_CURSOR: o_cmd.set_cursor = 1'b1;
                        bfr_pkg::REQ_CHAR: begin
                            if (i_char_code == bfr_pkg::CHAR_NL) begin
                                o_cmd.newline = 1'b1;
                            end else if (i_char_code != bfr_pkg::CHAR_NUL) begin
                                o_cmd.char_start = 1'b1;
                                n_state          = bfr_pkg::ST_BASE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bfr_pkg::ST_BASE: begin
                o_cmd.base = 1'b1;
                n_cnt      = '0;
                n_state    = bfr_pkg::ST_ROWS;
            end
            bfr_pkg::ST_ROWS: begin
                o_cmd.row_issue = 1'b1;
                if (r_cnt == LAST) begin
                    o_cmd.row_last = 1'b1;
                    n_state        = bfr_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = bfr_pkg::ST_IDLE;
        endcase
    end

    `BFR_ASSERT_NEXT(a_char_starts, i_clk, i_rst_n, r_state == bfr_pkg::ST_IDLE && i_start && i_req_type == bfr_pkg::REQ_CHAR && i_char_code != bfr_pkg::CHAR_NUL && i_char_code != bfr_pkg::CHAR_NL, r_state == bfr_pkg::ST_BASE && o_busy, "printable char did not start drawing")
    `BFR_ASSERT_IMPL(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.load_we, o_cmd.set_cursor, o_cmd.newline, o_cmd.char_start, o_cmd.base, o_cmd.row_issue}), "conflicting datapath commands")
    `BFR_ASSERT_NEXT(a_base_to_rows, i_clk, i_rst_n, r_state == bfr_pkg::ST_BASE, r_state == bfr_pkg::ST_ROWS && r_cnt == '0, "row walk did not start at row zero")
    `BFR_ASSERT_NEXT(a_last_row_done, i_clk, i_rst_n, r_state == bfr_pkg::ST_ROWS && r_cnt == LAST, r_state == bfr_pkg::ST_IDLE && !o_busy, "char did not finish after last row")

endmodule

`default_nettype wire

FILE: hw/rtl/bitmap_font_text_renderer_unit.sv
// top level of the bitmap font text renderer
// depends on bfr_pkg, bfr_regs, bfr_ctrl and bfr_dp
//
// channel   direction  handshake              payload
// request   in         start & !busy          i_req (bfr_pkg::t_req)
// result    out        o_strobe per row       o_res (bfr_pkg::t_res)
// config    in         psel/penable/pwrite    paddr, pwdata, prdata
//
// font loads, cursor sets, newlines and code zero leave busy low
// a printable char raises busy until its last glyph row is read:
// the accept cycle forms row times stride, the base state adds base and column,
// then one glyph store read per row
// rows appear on o_res from the cycle after the first read, one per cycle
// reset is synchronous, active low; the glyph store is not cleared
// the result receiver cannot stall
`default_nettype none

module bitmap_font_text_renderer_unit #(
    parameter int GLYPH_ROWS = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire bfr_pkg::t_req              i_req,
    output logic                            o_strobe,
    output bfr_pkg::t_res                   o_res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bfr_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    bfr_pkg::t_cfg    cfg;
    bfr_pkg::t_dp_cmd cmd;

    bfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bfr_ctrl #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req_type  (i_req.req_type),
        .i_char_code (i_req.char_code),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    bfr_dp #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .i_cfg    (cfg),
        .o_res    (o_res),
        .o_strobe (o_strobe)
    );

endmodule

`default_nettype wire
